// ===== hw/rtl/binary_to_text_line_encoder_top_assert.svh =====
// ----------------------------------------------------------------------------
// Line encoder assertion macros
// Shared property forms for the checker; clk and rst come from the user scope.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_TEXT_LINE_ENCODER_TOP_ASSERT_SVH
`define BINARY_TO_TEXT_LINE_ENCODER_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define BTLE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define BTLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/btle_pkg.sv =====
// ----------------------------------------------------------------------------
// Line encoder package
// Shared types and constants of the front end, command queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

package btle_pkg;

  // width of a line byte count (holds up to 63)
  localparam int LEN_W = 6;

  // line commands from front end to back end
  typedef struct packed {
    logic             line_en;
    logic             close_en;
    logic             bank;
    logic [LEN_W-1:0] len;
    logic [15:0]      crc;
  } cmd_t;

  // line buffer write from the front end
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [LEN_W-1:0] pos;
    logic [7:0]       data;
  } wr_t;

  // line buffer bank handed back by the back end
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_LEN,
    B_LOAD,
    B_CHAR,
    B_NL,
    B_CLM,
    B_CLNL
  } bstate_t;

endpackage

`default_nettype wire

// ===== hw/rtl/btle_raw_if.sv =====
// ----------------------------------------------------------------------------
// Raw byte channel
// Valid/ready channel carrying one input byte and its stream flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface btle_raw_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_stream;

  modport source (output valid, data_byte, byte_valid, end_of_stream, input ready);
  modport sink (input valid, data_byte, byte_valid, end_of_stream, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/btle_text_if.sv =====
// ----------------------------------------------------------------------------
// Text character channel
// Valid/ready channel carrying one encoded character with CRC and markers.
// ----------------------------------------------------------------------------
`default_nettype none

interface btle_text_if;
  logic        valid;
  logic        ready;
  logic [6:0]  out_char;
  logic [15:0] crc_value;
  logic        run_last;
  logic        stream_done;

  modport source (output valid, out_char, crc_value, run_last, stream_done, input ready);
  modport sink (input valid, out_char, crc_value, run_last, stream_done, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/btle_front.sv =====
// ----------------------------------------------------------------------------
// Line encoder front end
// Accepts bytes, updates count and CRC, fills the line buffer and issues
// one command per transaction that produces text.
// ----------------------------------------------------------------------------
`default_nettype none

module btle_front #(
  parameter int LINE_BYTES = 45
) (
  input  wire logic          clk,
  input  wire logic          rst,
  btle_raw_if.sink           raw,
  output btle_pkg::cmd_t     cmd,
  output logic               cmd_valid,
  input  wire logic          cmd_ready,
  output btle_pkg::wr_t      wr,
  input  wire btle_pkg::rel_t rel
);
  import btle_pkg::*;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  logic [LEN_W-1:0] count;
  logic [15:0]      crc;
  logic             wr_bank;
  logic [1:0]       busy;
  logic [1:0]       busy_next;

  logic             accept;
  logic [LEN_W-1:0] cnt_inc;
  logic [LEN_W-1:0] count_after;
  logic             full_line;
  logic             line_en;
  logic [15:0]      crc_next;

  // table entry for the byte-wise crc
  function automatic logic [15:0] crc_tab(input logic [7:0] idx);
    logic [15:0] v;
    v = {idx, 8'h00};
    for (int b = 0; b < 8; b++) begin
      v = v[15] ? ((v << 1) ^ CRC_POLY) : (v << 1);
    end
    return v;
  endfunction

  // classify the transaction
  assign raw.ready   = cmd_ready && !busy[wr_bank];
  assign accept      = raw.valid && raw.ready;
  assign cnt_inc     = count + LEN_W'(1);
  assign count_after = raw.byte_valid ? cnt_inc : count;
  assign full_line   = raw.byte_valid && (cnt_inc == LEN_W'(LINE_BYTES));
  assign line_en     = full_line || (raw.end_of_stream && (count_after != '0));
  assign crc_next    = crc_tab(crc[15:8]) ^ {crc[7:0], 8'h00} ^ {8'h00, raw.data_byte};

  // command toward the back end
  assign cmd_valid    = accept && (line_en || raw.end_of_stream);
  assign cmd.line_en  = line_en;
  assign cmd.close_en = raw.end_of_stream;
  assign cmd.bank     = wr_bank;
  assign cmd.len      = count_after;
  assign cmd.crc      = raw.byte_valid ? crc_next : crc;

  // line buffer write
  assign wr.en   = accept && raw.byte_valid;
  assign wr.bank = wr_bank;
  assign wr.pos  = count;
  assign wr.data = raw.data_byte;

  // bank ownership
  always_comb begin
    busy_next = busy;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (accept && line_en) begin
      busy_next[wr_bank] = 1'b1;
    end
  end

  // line and crc state
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      crc     <= '0;
      wr_bank <= 1'b0;
      busy    <= '0;
    end else begin
      busy <= busy_next;
      if (accept) begin
        if (raw.end_of_stream) begin
          crc <= '0;
        end else if (raw.byte_valid) begin
          crc <= crc_next;
        end
        if (raw.end_of_stream || full_line) begin
          count <= '0;
        end else begin
          count <= count_after;
        end
        if (line_en) begin
          wr_bank <= !wr_bank;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/btle_cmdq.sv =====
// ----------------------------------------------------------------------------
// Line encoder command queue
// Two-entry queue between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module btle_cmdq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire btle_pkg::cmd_t push_cmd,
  input  wire logic           push,
  output logic                push_ready,
  output btle_pkg::cmd_t      pop_cmd,
  output logic                pop_valid,
  input  wire logic           pop
);
  import btle_pkg::*;

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_cmd    = entry[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/btle_back.sv =====
// ----------------------------------------------------------------------------
// Line encoder back end
// Holds the two-bank line buffer and sequences each command into characters.
// ----------------------------------------------------------------------------
`default_nettype none

module btle_back #(
  parameter int LINE_BYTES = 45
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire btle_pkg::cmd_t q_cmd,
  input  wire logic           q_valid,
  output logic                q_pop,
  input  wire btle_pkg::wr_t  wr,
  output btle_pkg::rel_t      rel,
  btle_text_if.source         text
);
  import btle_pkg::*;

  localparam int DEPTH = 2 * LINE_BYTES;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [6:0] CH_NL = 7'h0A;
  localparam logic [6:0] CH_M  = 7'h6D;
  localparam logic [6:0] CH_D  = 7'h64;
  localparam logic [6:0] CH_E  = 7'h65;
  localparam logic [6:0] CH_F  = 7'h66;
  localparam logic [6:0] CH_G  = 7'h67;
  localparam logic [6:0] CH_H  = 7'h68;

  logic [7:0]       mem [DEPTH];
  logic [7:0]       rdata;
  logic             rd_ok;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;

  bstate_t          state;
  bstate_t          state_next;
  cmd_t             cur;
  logic [1:0]       step;
  logic [LEN_W-1:0] base;
  logic [7:0]       g0;
  logic [7:0]       g1;
  logic [7:0]       g2;
  logic [LEN_W-1:0] pos;
  logic             pos_ok;
  logic [LEN_W-1:0] base_inc;

  logic             take;
  logic             emit;
  logic [6:0]       ech;
  logic             elast;
  logic             edone;
  logic [5:0]       sextet;

  logic             oval;
  logic [6:0]       ochar;
  logic [15:0]      ocrc;
  logic             olast;
  logic             odone;

  // 6-bit value to printable character
  function automatic logic [6:0] enc6(input logic [5:0] v);
    logic [6:0] c;
    c = {1'b0, v} + 7'h20;
    case (c)
      7'h20:   c = CH_M;
      7'h5B:   c = CH_D;
      7'h5C:   c = CH_E;
      7'h5D:   c = CH_F;
      7'h5E:   c = CH_G;
      7'h27:   c = CH_H;
      default: c = c;
    endcase
    return c;
  endfunction

  // line buffer ports
  assign waddr  = (wr.bank ? AW'(LINE_BYTES) : AW'(0)) + AW'(wr.pos);
  assign pos    = base + LEN_W'(step);
  assign pos_ok = (pos < cur.len);
  assign raddr  = pos_ok ? ((cur.bank ? AW'(LINE_BYTES) : AW'(0)) + AW'(pos)) : AW'(0);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[waddr] <= wr.data;
    end
    rdata <= mem[raddr];
    rd_ok <= pos_ok;
  end

  // group character select
  always_comb begin
    case (step)
      2'd0:    sextet = g0[7:2];
      2'd1:    sextet = {g0[1:0], g1[7:4]};
      2'd2:    sextet = {g1[3:0], g2[7:6]};
      default: sextet = g2[5:0];
    endcase
  end

  assign take     = !oval || text.ready;
  assign base_inc = base + LEN_W'(3);

  // sequencer next state and emitted character
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    emit       = 1'b0;
    ech        = CH_NL;
    elast      = 1'b0;
    edone      = 1'b0;
    rel.valid  = 1'b0;
    rel.bank   = cur.bank;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = q_cmd.line_en ? B_LEN : B_CLM;
        end
      end
      B_LEN: begin
        emit = 1'b1;
        ech  = enc6(cur.len);
        if (take) begin
          state_next = B_LOAD;
        end
      end
      B_LOAD: begin
        if (step == 2'd3) begin
          state_next = B_CHAR;
        end
      end
      B_CHAR: begin
        emit = 1'b1;
        ech  = enc6(sextet);
        if (take && step == 2'd3) begin
          state_next = (base_inc >= cur.len) ? B_NL : B_LOAD;
        end
      end
      B_NL: begin
        emit  = 1'b1;
        ech   = CH_NL;
        elast = !cur.close_en;
        if (take) begin
          rel.valid  = 1'b1;
          state_next = cur.close_en ? B_CLM : B_IDLE;
        end
      end
      B_CLM: begin
        emit = 1'b1;
        ech  = CH_M;
        if (take) begin
          state_next = B_CLNL;
        end
      end
      B_CLNL: begin
        emit  = 1'b1;
        ech   = CH_NL;
        elast = 1'b1;
        edone = 1'b1;
        if (take) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // command, group position and gathered bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      base <= '0;
    end else if (q_pop) begin
      step <= '0;
      base <= '0;
    end else if (state == B_LOAD || (state == B_CHAR && take)) begin
      step <= step + 2'd1;
      if (state == B_CHAR && step == 2'd3) begin
        base <= base_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
    end
    if (state == B_LOAD) begin
      case (step)
        2'd1:    g0 <= rd_ok ? rdata : 8'h00;
        2'd2:    g1 <= rd_ok ? rdata : 8'h00;
        2'd3:    g2 <= rd_ok ? rdata : 8'h00;
        default: g0 <= g0;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      oval <= 1'b0;
    end else if (emit && take) begin
      oval <= 1'b1;
    end else if (text.ready) begin
      oval <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && take) begin
      ochar <= ech;
      ocrc  <= cur.crc;
      olast <= elast;
      odone <= edone;
    end
  end

  assign text.valid       = oval;
  assign text.out_char    = ochar;
  assign text.crc_value   = ocrc;
  assign text.run_last    = olast;
  assign text.stream_done = odone;

endmodule

`default_nettype wire

// ===== hw/rtl/binary_to_text_line_encoder_top.sv =====
// ----------------------------------------------------------------------------
// Binary to text line encoder
// Encodes a byte stream into length-prefixed text lines with a running CRC-16.
// ----------------------------------------------------------------------------
// The front end can take one byte transaction per cycle while not stalled. The
// back end takes a command from the queue, sends the length character, then
// for each group of three bytes reads them from the line buffer over its
// single read port and sends them as four characters, and ends the line with
// a newline; the closing empty line is an m and a newline. No character is
// emitted while a group is read. The front end keeps taking bytes into the
// second line buffer bank while the back end sends the first; it stalls only
// when both banks hold lines not yet sent or the two-entry command queue is
// full. Every character carries the CRC after the bytes of its transaction;
// the closing newline carries the CRC of the whole stream.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_text_line_encoder_top #(
  parameter int LINE_BYTES = 45
) (
  input  wire logic   clk,
  input  wire logic   rst,
  btle_raw_if.sink    raw,
  btle_text_if.source text
);
  import btle_pkg::*;

  cmd_t fq_cmd;
  logic fq_valid;
  logic fq_ready;
  cmd_t qb_cmd;
  logic qb_valid;
  logic qb_pop;
  wr_t  wr;
  rel_t rel;

  // byte intake and classification
  btle_front #(.LINE_BYTES(LINE_BYTES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .raw       (raw),
    .cmd       (fq_cmd),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .wr        (wr),
    .rel       (rel)
  );

  // command queue
  btle_cmdq u_cmdq (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (fq_cmd),
    .push       (fq_valid),
    .push_ready (fq_ready),
    .pop_cmd    (qb_cmd),
    .pop_valid  (qb_valid),
    .pop        (qb_pop)
  );

  // line buffer and character sequencer
  btle_back #(.LINE_BYTES(LINE_BYTES)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_cmd   (qb_cmd),
    .q_valid (qb_valid),
    .q_pop   (qb_pop),
    .wr      (wr),
    .rel     (rel),
    .text    (text)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/btle_checker.sv =====
// ----------------------------------------------------------------------------
// Line encoder port checker
// Checks the character channel of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_to_text_line_encoder_top_assert.svh"

module btle_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [6:0]  out_char,
  input wire logic        run_last,
  input wire logic        stream_done
);

  // the closing newline also ends its transaction
  `BTLE_ASSERT_SAME(a_done_last, out_valid && stream_done, run_last, "stream end without run end")

  // the closing character is a newline
  `BTLE_ASSERT_SAME(a_done_nl, out_valid && stream_done, out_char == 7'h0A, "stream end not newline")

  // only newline or printable encoded characters appear
  `BTLE_ASSERT_SAME(a_char_range, out_valid, (out_char == 7'h0A) || ((out_char >= 7'h21) && (out_char <= 7'h6D)), "character out of range")

  // a stalled character stays put
  `BTLE_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_char), "stalled character changed")

endmodule

bind binary_to_text_line_encoder_top btle_checker u_btle_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (text.valid),
  .out_ready   (text.ready),
  .out_char    (text.out_char),
  .run_last    (text.run_last),
  .stream_done (text.stream_done)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Line encoder testbench
// Feeds byte streams through the raw channel and checks every text character,
// its CRC and its markers against an in-bench encoder; directed rows first,
// then random streams with random idling, a long receiver hold-off and a drain.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int LINE_BYTES   = 45;
  localparam int ITEMS        = 370;
  localparam int IDLE_PCT     = 7;
  localparam int NOISE_PCT    = 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 200;
  localparam int QUIET_LIMIT  = 4000;
  localparam int MAX_REPORTS  = 100;

  // character codes
  localparam bit [6:0] CH_NL   = 7'h0A;
  localparam bit [6:0] CH_M    = 7'h6D;
  localparam bit [6:0] CH_LEN1 = 7'h21;
  localparam bit [6:0] CH_TOP6 = 7'h5F;   // all six bits set
  localparam bit [6:0] CH_HI2  = 7'h50;   // two high bits of a byte's low pair

  localparam bit [0:7][6:0] NO_CHARS = '0;

  // one character as it leaves the text channel
  typedef struct packed {
    bit [6:0]  ch;
    bit [15:0] crc;
    bit        last;
    bit        done;
  } text_item_t;

  // one byte transaction; typed rows carry their characters inline
  typedef struct packed {
    bit [7:0]         data;
    bit               bv;
    bit               eos;
    bit               typed;
    bit [3:0]         n;
    bit [15:0]        crc;
    bit [0:7][6:0]    chars;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [19] = '{
    // neither byte nor end
    '{8'hA5, 1'b0, 1'b0, 1'b1, 4'd0, 16'h0000, NO_CHARS},
    // end of an empty stream right after reset
    '{8'h00, 1'b0, 1'b1, 1'b1, 4'd2, 16'h0000, {CH_M, CH_NL, 42'h0}},
    // lowest byte and end together, short group padded with zeros
    '{8'h00, 1'b1, 1'b1, 1'b1, 4'd8, 16'h0000,
      {CH_LEN1, CH_M, CH_M, CH_M, CH_M, CH_NL, CH_M, CH_NL}},
    // highest byte and end together
    '{8'hFF, 1'b1, 1'b1, 1'b1, 4'd8, 16'h00FF,
      {CH_LEN1, CH_TOP6, CH_HI2, CH_M, CH_M, CH_NL, CH_M, CH_NL}},
    // bytes whose top six bits hit every substituted character
    '{8'hEC, 1'b1, 1'b0, 1'b0, 4'd0, 16'h0000, NO_CHARS},
    '{8'hF0, 1'b1, 1'b0, 1'b0, 4'd0, 16'h0000, NO_CHARS},
    '{8'hF4, 1'b1, 1'b0, 1'b0, 4'd0, 16'h0000, NO_CHARS},
    '{8'hF8, 1'b1, 1'b0, 1'b0, 4'd0, 16'h0000, NO_CHARS},
    '{8'h1C, 1'b1, 1'b0, 1'b0, 4'd0, 16'h0000, NO_CHARS},
    '{8'h00, 1'b1, 1'b0, 1'b0, 4'd0, 16'h0000, NO_CHARS},
    '{8'h3C, 1'b0, 1'b1, 1'b0, 4'd0, 16'h0000, NO_CHARS},
    // two bytes, one missing from the last group
    '{8'hAA, 1'b1, 1'b0, 1'b0, 4'd0, 16'h0000, NO_CHARS},
    '{8'h55, 1'b1, 1'b1, 1'b0, 4'd0, 16'h0000, NO_CHARS},
    // ignored transaction with a full data byte
    '{8'hFF, 1'b0, 1'b0, 1'b1, 4'd0, 16'h0000, NO_CHARS},
    // one whole group, then an end-only transaction with junk data
    '{8'h01, 1'b1, 1'b0, 1'b0, 4'd0, 16'h0000, NO_CHARS},
    '{8'h02, 1'b1, 1'b0, 1'b0, 4'd0, 16'h0000, NO_CHARS},
    '{8'h03, 1'b1, 1'b0, 1'b0, 4'd0, 16'h0000, NO_CHARS},
    '{8'hFF, 1'b0, 1'b1, 1'b0, 4'd0, 16'h0000, NO_CHARS},
    '{8'h80, 1'b1, 1'b1, 1'b0, 4'd0, 16'h0000, NO_CHARS}
  };

  logic clk;
  logic rst;
  logic steady;
  logic hold_req;

  btle_raw_if  raw_ch ();
  btle_text_if text_ch ();

  binary_to_text_line_encoder_top #(
    .LINE_BYTES(LINE_BYTES)
  ) u_dut (
    .clk  (clk),
    .rst  (rst),
    .raw  (raw_ch),
    .text (text_ch)
  );

  // encoder state mirrored in the bench
  bit [7:0]   model_line [LINE_BYTES];
  int         model_len;
  bit [15:0]  model_crc;
  text_item_t line_chars[$];

  text_item_t pending_chars[$];
  stim_row_t  offered_rows[$];
  int         items_sent;
  int         fail_count;

  // crc table entry, polynomial 0x1021
  function automatic bit [15:0] crc_tab(bit [7:0] idx);
    bit [15:0] v;
    v = {idx, 8'h00};
    for (int b = 0; b < 8; b++) begin
      v = v[15] ? ((v << 1) ^ 16'h1021) : (v << 1);
    end
    return v;
  endfunction

  // six-bit value to printable character
  function automatic bit [6:0] text_char(bit [5:0] v);
    bit [6:0] c;
    c = {1'b0, v} + 7'h20;
    case (c)
      7'h20: c = CH_M;
      7'h5B: c = 7'h64;   // d
      7'h5C: c = 7'h65;   // e
      7'h5D: c = 7'h66;   // f
      7'h5E: c = 7'h67;   // g
      7'h27: c = 7'h68;   // h
      default: ;
    endcase
    return c;
  endfunction

  function automatic void put_char(bit [6:0] ch, bit done);
    line_chars.push_back('{ch, model_crc, 1'b0, done});
  endfunction

  // length character, groups of three bytes, newline
  function automatic void emit_line();
    bit [7:0] a, b, c;
    put_char(text_char(6'(model_len)), 1'b0);
    for (int i = 0; i < model_len; i += 3) begin
      a = model_line[i];
      b = (i + 1 < model_len) ? model_line[i + 1] : 8'h00;
      c = (i + 2 < model_len) ? model_line[i + 2] : 8'h00;
      put_char(text_char(a[7:2]), 1'b0);
      put_char(text_char({a[1:0], b[7:4]}), 1'b0);
      put_char(text_char({b[3:0], c[7:6]}), 1'b0);
      put_char(text_char(c[5:0]), 1'b0);
    end
    put_char(CH_NL, 1'b0);
    model_len = 0;
  endfunction

  // characters caused by one byte transaction, left in line_chars
  function automatic void encode_item(bit [7:0] data, bit bv, bit eos);
    line_chars.delete();
    if (bv) begin
      model_line[model_len] = data;
      model_len++;
      model_crc = crc_tab(model_crc[15:8]) ^ {model_crc[7:0], 8'h00} ^ {8'h00, data};
      if (model_len >= LINE_BYTES) emit_line();
    end
    if (eos) begin
      if (model_len > 0) emit_line();
      put_char(CH_M, 1'b0);
      put_char(CH_NL, 1'b1);
      model_len = 0;
      model_crc = '0;
    end
    if (line_chars.size() > 0) line_chars[line_chars.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
    end
  endfunction

  function automatic stim_row_t byte_row(bit [7:0] d, bit bv, bit eos);
    return '{d, bv, eos, 1'b0, 4'd0, 16'h0000, NO_CHARS};
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // check text transactions, then predict from accepted byte transactions
  always @(posedge clk) begin
    text_item_t want;
    stim_row_t  row;
    if (!rst && text_ch.valid && text_ch.ready) begin
      if (pending_chars.size() == 0) begin
        fail_count++;
        $error("character 0x%0h arrived with no transaction waiting", text_ch.out_char);
      end else begin
        want = pending_chars.pop_front();
        check_field("out_char", want.ch, text_ch.out_char);
        check_field("crc_value", want.crc, text_ch.crc_value);
        check_field("run_last", want.last, text_ch.run_last);
        check_field("stream_done", want.done, text_ch.stream_done);
      end
    end
    if (!rst && raw_ch.valid && raw_ch.ready) begin
      row = offered_rows.pop_front();
      encode_item(row.data, row.bv, row.eos);
      if (row.typed) begin
        for (int k = 0; k < row.n; k++)
          pending_chars.push_back('{row.chars[k], row.crc, 1'(k == row.n - 1),
                                    1'(row.eos && k == row.n - 1)});
      end else begin
        foreach (line_chars[k]) pending_chars.push_back(line_chars[k]);
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    bit held;
    held = 1'b0;
    text_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        text_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        text_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (raw_ch.valid && raw_ch.ready) || (text_ch.valid && text_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // present one transaction and wait for it to be taken
  task automatic offer(input stim_row_t row);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      raw_ch.valid     <= 1'b0;
      raw_ch.data_byte <= 8'($urandom);
      @(posedge clk);
    end
    offered_rows.push_back(row);
    raw_ch.valid         <= 1'b1;
    raw_ch.data_byte     <= row.data;
    raw_ch.byte_valid    <= row.bv;
    raw_ch.end_of_stream <= row.eos;
    do @(posedge clk); while (!raw_ch.ready);
    if (row.bv || row.eos) items_sent++;
  endtask

  // one stream of random bytes with stray ignored transactions
  task automatic send_stream(input int len, input bit eos_on_last);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < NOISE_PCT)
        offer(byte_row(8'($urandom), 1'b0, 1'b0));
      offer(byte_row(8'($urandom), 1'b1, 1'(eos_on_last && i == len - 1)));
    end
    if (!eos_on_last || len == 0)
      offer(byte_row(8'($urandom), 1'b0, 1'b1));
  endtask

  // mostly short streams, some around one and two full lines
  task automatic random_stream();
    int pick, len;
    pick = $urandom_range(99);
    if (pick < 8)       len = LINE_BYTES;
    else if (pick < 16) len = $urandom_range(LINE_BYTES - 2, LINE_BYTES + 2);
    else if (pick < 24) len = $urandom_range(2 * LINE_BYTES - 2, 2 * LINE_BYTES + 2);
    else if (pick < 70) len = $urandom_range(0, 12);
    else                len = $urandom_range(13, 60);
    send_stream(len, 1'($urandom_range(1)));
  endtask

  // hold the sender until every expected character is out
  task automatic wait_for_text();
    raw_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_chars.size() != 0 || offered_rows.size() != 0);
  endtask

  // stimulus
  initial begin
    model_len  = 0;
    model_crc  = '0;
    items_sent = 0;
    fail_count = 0;
    foreach (model_line[i]) model_line[i] = '0;
    rst                  <= 1'b1;
    steady               <= 1'b0;
    hold_req             <= 1'b0;
    raw_ch.valid         <= 1'b0;
    raw_ch.data_byte     <= '0;
    raw_ch.byte_valid    <= 1'b0;
    raw_ch.end_of_stream <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i]) offer(DIRECTED_ROWS[i]);
    wait_for_text();

    // line filled by the byte that also ends the stream
    send_stream(LINE_BYTES, 1'b1);
    while (items_sent < 140) random_stream();
    wait_for_text();

    // receiver holds off while a long stream keeps coming
    steady   <= 1'b1;
    hold_req <= 1'b1;
    send_stream(120, 1'b0);
    while (items_sent < 300) random_stream();
    steady <= 1'b0;
    while (items_sent < ITEMS) random_stream();

    wait_for_text();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_chars.size() != 0) begin
      fail_count++;
      $error("%0d expected characters never arrived", pending_chars.size());
    end
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== binary_to_text_line_encoder_top.f =====
+incdir+hw/rtl
hw/rtl/btle_pkg.sv
hw/rtl/btle_raw_if.sv
hw/rtl/btle_text_if.sv
hw/rtl/btle_front.sv
hw/rtl/btle_cmdq.sv
hw/rtl/btle_back.sv
hw/rtl/binary_to_text_line_encoder_top.sv
hw/rtl/btle_checker.sv
tb/sv/tb.sv
